/* src/gsm_pkg.sv */
// Shared types, codes and constants for the golden-section minimizer.
package gsm_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int WIDE_WIDTH          = 64;

   // Golden ratio complement 0.38196601 as unsigned Q0.16.
   localparam int        Q_SHIFT    = 16;
   localparam logic [15:0] G2_Q16   = 16'd25033;
   localparam logic [15:0] ROUND_HALF = 16'h8000;

   localparam int TOL_WIDTH      = 16;
   localparam int COUNT_WIDTH    = 10;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [TOL_WIDTH-1:0]   TOL_RESET      = 16'd66;
   localparam logic [COUNT_WIDTH-1:0] MAX_EVAL_RESET = 10'd64;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TOLERANCE = 2'd0,
      CSR_MAX_EVAL  = 2'd1
   } csr_index_type;

   typedef enum logic {
      MODE_START = 1'b0,
      MODE_VALUE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      KIND_EVAL  = 2'd0,
      KIND_FINAL = 2'd1,
      KIND_IDLE  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_FIRST_LEFT  = 3'd1,
      PH_FIRST_RIGHT = 3'd2,
      PH_LEFT        = 3'd3,
      PH_RIGHT       = 3'd4
   } phase_type;

   typedef struct packed {
      logic [TOL_WIDTH-1:0]   tolerance;
      logic [COUNT_WIDTH-1:0] max_evaluations;
   } cfg_type;

endpackage

/* src/gsm_step.sv */
// Golden step unit: x + G2 * (y - x), rounded to nearest on the magnitude.
module gsm_step #(
   parameter int VALUE_WIDTH = gsm_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic signed [VALUE_WIDTH-1:0] x,
   input  logic signed [VALUE_WIDTH-1:0] y,
   output logic signed [VALUE_WIDTH-1:0] probe
);
   import gsm_pkg::*;

   localparam int PW = VALUE_WIDTH + Q_SHIFT;

   logic [VALUE_WIDTH-1:0] mag;
   logic [PW-1:0]          prod;
   logic [PW-1:0]          rounded;
   logic [VALUE_WIDTH-1:0] q;

   always_comb begin
      mag     = (y >= x) ? VALUE_WIDTH'(y - x) : VALUE_WIDTH'(x - y);
      prod    = PW'(mag) * PW'(G2_Q16);
      rounded = prod + PW'(ROUND_HALF);
      q       = rounded[PW-1:Q_SHIFT];
      // move toward y; the result stays between x and y
      probe   = (y >= x) ? (x + $signed(q)) : (x - $signed(q));
   end

endmodule

/* src/gsm_stop.sv */
// Convergence test: |end_high - end_low| <= tol * (|inner_left| + |inner_right|).
module gsm_stop #(
   parameter int VALUE_WIDTH = gsm_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic signed [VALUE_WIDTH-1:0]  end_low,
   input  logic signed [VALUE_WIDTH-1:0]  end_high,
   input  logic signed [VALUE_WIDTH-1:0]  inner_left,
   input  logic signed [VALUE_WIDTH-1:0]  inner_right,
   input  logic [gsm_pkg::TOL_WIDTH-1:0]  tolerance,
   output logic                           near
);
   import gsm_pkg::*;

   localparam int  SW  = VALUE_WIDTH + 1;
   localparam int  PW  = SW + TOL_WIDTH;
   localparam bit  CAP = (VALUE_WIDTH >= WIDE_WIDTH);

   logic [VALUE_WIDTH-1:0] mag_left;
   logic [VALUE_WIDTH-1:0] mag_right;
   logic [SW-1:0]          sum_raw;
   logic [SW-1:0]          sum_cap;
   logic [PW-1:0]          prod;
   logic [SW-1:0]          bound;
   logic [VALUE_WIDTH-1:0] gap;

   always_comb begin
      mag_left  = inner_left[VALUE_WIDTH-1]  ? VALUE_WIDTH'(-inner_left)  :
                                               VALUE_WIDTH'(inner_left);
      mag_right = inner_right[VALUE_WIDTH-1] ? VALUE_WIDTH'(-inner_right) :
                                               VALUE_WIDTH'(inner_right);
      sum_raw   = SW'(mag_left) + SW'(mag_right);
      // at VALUE_WIDTH >= WIDE_WIDTH, saturate the sum at the largest VALUE_WIDTH-bit magnitude
      sum_cap   = (CAP && sum_raw[VALUE_WIDTH]) ? {1'b0, {VALUE_WIDTH{1'b1}}} : sum_raw;
      prod      = PW'(sum_cap) * PW'(tolerance);
      bound     = prod[PW-1:Q_SHIFT];
      gap       = (end_high >= end_low) ? VALUE_WIDTH'(end_high - end_low) :
                                          VALUE_WIDTH'(end_low - end_high);
      near      = (SW'(gap) <= bound);
   end

endmodule

/* src/gsm_core.sv */
// Search state and per-word update: bracket load, value capture, step or finish.
module gsm_core #(
   parameter int VALUE_WIDTH = gsm_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire,
   input  gsm_pkg::cfg_type               cfg,
   input  gsm_pkg::mode_type              mode,
   input  logic signed [VALUE_WIDTH-1:0]  point_a,
   input  logic signed [VALUE_WIDTH-1:0]  point_b,
   input  logic signed [VALUE_WIDTH-1:0]  point_c,
   input  logic signed [VALUE_WIDTH-1:0]  func_value,
   output gsm_pkg::kind_type              result_kind,
   output logic signed [VALUE_WIDTH-1:0]  point,
   output logic signed [VALUE_WIDTH-1:0]  min_value
);
   import gsm_pkg::*;

   phase_type                  phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]     count_ff, count_in;
   logic signed [VALUE_WIDTH-1:0] end_low_ff, end_low_in;
   logic signed [VALUE_WIDTH-1:0] end_high_ff, end_high_in;
   logic signed [VALUE_WIDTH-1:0] inner_left_ff, inner_left_in;
   logic signed [VALUE_WIDTH-1:0] inner_right_ff, inner_right_in;
   logic signed [VALUE_WIDTH-1:0] value_left_ff, value_left_in;
   logic signed [VALUE_WIDTH-1:0] value_right_ff, value_right_in;

   logic signed [VALUE_WIDTH-1:0] step_left_x, step_left_y, step_left;
   logic signed [VALUE_WIDTH-1:0] step_right_x, step_right_y, step_right;
   logic                          near;
   logic                          start;

   function automatic logic [VALUE_WIDTH-1:0] abs_diff(
      input logic signed [VALUE_WIDTH-1:0] x,
      input logic signed [VALUE_WIDTH-1:0] y
   );
      return (x >= y) ? VALUE_WIDTH'(x - y) : VALUE_WIDTH'(y - x);
   endfunction

   assign start = (mode == MODE_START);

   // start: probe either half from b; running: step each inner point outward
   assign step_left_x  = start ? point_b : inner_left_ff;
   assign step_left_y  = start ? point_a : end_low_ff;
   assign step_right_x = start ? point_b : inner_right_ff;
   assign step_right_y = start ? point_c : end_high_ff;

   gsm_step #(.VALUE_WIDTH(VALUE_WIDTH)) u_step_left (
      .x     (step_left_x),
      .y     (step_left_y),
      .probe (step_left)
   );

   gsm_step #(.VALUE_WIDTH(VALUE_WIDTH)) u_step_right (
      .x     (step_right_x),
      .y     (step_right_y),
      .probe (step_right)
   );

   gsm_stop #(.VALUE_WIDTH(VALUE_WIDTH)) u_stop (
      .end_low     (end_low_ff),
      .end_high    (end_high_ff),
      .inner_left  (inner_left_ff),
      .inner_right (inner_right_ff),
      .tolerance   (cfg.tolerance),
      .near        (near)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         end_low_ff     <= end_low_in;
         end_high_ff    <= end_high_in;
         inner_left_ff  <= inner_left_in;
         inner_right_ff <= inner_right_in;
         value_left_ff  <= value_left_in;
         value_right_ff <= value_right_in;
      end
   end

   always_comb begin
      logic adv;
      adv            = 1'b0;
      phase_in       = phase_ff;
      count_in       = count_ff;
      end_low_in     = end_low_ff;
      end_high_in    = end_high_ff;
      inner_left_in  = inner_left_ff;
      inner_right_in = inner_right_ff;
      value_left_in  = value_left_ff;
      value_right_in = value_right_ff;
      result_kind    = KIND_IDLE;
      point          = '0;
      min_value      = '0;

      if (start) begin
         end_low_in     = point_a;
         end_high_in    = point_c;
         value_left_in  = '0;
         value_right_in = '0;
         count_in       = '0;
         phase_in       = PH_FIRST_LEFT;
         if (abs_diff(point_c, point_b) > abs_diff(point_b, point_a)) begin
            inner_left_in  = point_b;
            inner_right_in = step_right;
         end else begin
            inner_left_in  = step_left;
            inner_right_in = point_b;
         end
         result_kind = KIND_EVAL;
         point       = inner_left_in;
      end else begin
         unique case (phase_ff)
            PH_FIRST_LEFT: begin
               value_left_in = func_value;
               count_in      = COUNT_WIDTH'(1);
               phase_in      = PH_FIRST_RIGHT;
               result_kind   = KIND_EVAL;
               point         = inner_right_ff;
            end
            PH_FIRST_RIGHT: begin
               value_right_in = func_value;
               count_in       = COUNT_WIDTH'(2);
               adv            = 1'b1;
            end
            PH_LEFT: begin
               value_left_in = func_value;
               count_in      = count_ff + 1'b1;
               adv           = 1'b1;
            end
            PH_RIGHT: begin
               value_right_in = func_value;
               count_in       = count_ff + 1'b1;
               adv            = 1'b1;
            end
            default: begin
               result_kind = KIND_IDLE;
            end
         endcase

         if (adv) begin
            if (near || (count_in >= cfg.max_evaluations)) begin
               phase_in    = PH_IDLE;
               result_kind = KIND_FINAL;
               if (value_left_in < value_right_in) begin
                  point     = inner_left_ff;
                  min_value = value_left_in;
               end else begin
                  point     = inner_right_ff;
                  min_value = value_right_in;
               end
            end else if (value_right_in > value_left_in) begin
               // keep the left sub-bracket
               end_high_in    = inner_right_ff;
               inner_right_in = inner_left_ff;
               value_right_in = value_left_in;
               inner_left_in  = step_left;
               phase_in       = PH_LEFT;
               result_kind    = KIND_EVAL;
               point          = step_left;
            end else begin
               // keep the right sub-bracket; ties land here
               end_low_in    = inner_left_ff;
               inner_left_in = inner_right_ff;
               value_left_in = value_right_in;
               inner_right_in = step_right;
               phase_in      = PH_RIGHT;
               result_kind   = KIND_EVAL;
               point         = step_right;
            end
         end
      end
   end

endmodule

/* src/golden_section_minimizer.sv */
// Golden-section minimizer top level: handshakes, input and result registers, CSRs.
// A word waits in the input register until the core fires and fills the rsp_ registers.
// Throughput: one word per cycle unless stalled; a single update sits between the registers.
// Reset: synchronous, active high; clears valid flags and search phase, loads CSR defaults
// (tolerance 66, max_evaluations 64). No clearing pass is needed.
module golden_section_minimizer #(
   parameter int VALUE_WIDTH = gsm_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic signed [VALUE_WIDTH-1:0]        req_point_a,
   input  logic signed [VALUE_WIDTH-1:0]        req_point_b,
   input  logic signed [VALUE_WIDTH-1:0]        req_point_c,
   input  logic signed [VALUE_WIDTH-1:0]        req_func_value,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_result_kind,
   output logic signed [VALUE_WIDTH-1:0]        rsp_point,
   output logic signed [VALUE_WIDTH-1:0]        rsp_min_value,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gsm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [gsm_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import gsm_pkg::*;

   // Input register: holds the accepted word until the core consumes it.
   logic                          in_valid_ff, in_valid_in;
   mode_type                      mode_ff;
   logic signed [VALUE_WIDTH-1:0] point_a_ff, point_b_ff, point_c_ff, func_value_ff;

   // Result register: decouples the core from a stalled consumer.
   logic                          out_valid_ff, out_valid_in;
   kind_type                      kind_ff;
   logic signed [VALUE_WIDTH-1:0] point_ff, min_value_ff;

   cfg_type                       cfg_ff, cfg_in;

   kind_type                      core_kind;
   logic signed [VALUE_WIDTH-1:0] core_point, core_min_value;

   logic                          fire;
   logic                          req_take;

   // The core advances whenever it holds a word and the result register is free
   // or being drained this cycle. Every word yields exactly one result word.
   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   // CSR writes are expected only while the search is quiet; always ready.
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end

      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_TOLERANCE: cfg_in.tolerance       = csr_data[TOL_WIDTH-1:0];
            CSR_MAX_EVAL:  cfg_in.max_evaluations = csr_data[COUNT_WIDTH-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
         cfg_ff.tolerance       <= TOL_RESET;
         cfg_ff.max_evaluations <= MAX_EVAL_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Capture the request word on acceptance.
   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff       <= mode_type'(req_mode);
         point_a_ff    <= req_point_a;
         point_b_ff    <= req_point_b;
         point_c_ff    <= req_point_c;
         func_value_ff <= req_func_value;
      end
   end

   // Load the result word when the core fires; hold it while stalled.
   always_ff @(posedge clock) begin
      if (fire) begin
         kind_ff      <= core_kind;
         point_ff     <= core_point;
         min_value_ff <= core_min_value;
      end
   end

   gsm_core #(.VALUE_WIDTH(VALUE_WIDTH)) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .cfg         (cfg_ff),
      .mode        (mode_ff),
      .point_a     (point_a_ff),
      .point_b     (point_b_ff),
      .point_c     (point_c_ff),
      .func_value  (func_value_ff),
      .result_kind (core_kind),
      .point       (core_point),
      .min_value   (core_min_value)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_point       = point_ff;
   assign rsp_min_value   = min_value_ff;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the golden-section minimizer: scoreboard class, drivers and checks.
`timescale 1ns / 1ps

module tb_top;
   import gsm_pkg::*;

   localparam int      VW          = VALUE_WIDTH_DEFAULT;
   localparam int      WORD_TARGET = 400;
   localparam int      CYCLE_LIMIT = 500000;
   localparam longint  TOP_VALUE   = 64'sh7FFF_FFFF;

   // One result word as the block should send it.
   typedef struct {
      kind_type      kind;
      logic [VW-1:0] point;
      logic [VW-1:0] min_value;
   } answer_type;

   // Tracks the search the block runs and holds the answers still due from it.
   class minimizer_board_type;
      bit [TOL_WIDTH-1:0]   tolerance = TOL_RESET;
      bit [COUNT_WIDTH-1:0] max_evaluations = MAX_EVAL_RESET;
      longint               low_end, high_end, left_pt, right_pt, left_val, right_val;
      phase_type            phase;
      bit [COUNT_WIDTH-1:0] eval_count;
      longint               asked_point;
      answer_type           due_answers[$];
      int                   failures = 0;
      int                   checked = 0;
      int                   starts = 0;
      int                   values = 0;
      int                   answers = 0;
      int                   strays = 0;

      function new();
         low_end = 0;
         high_end = 0;
         left_pt = 0;
         right_pt = 0;
         left_val = 0;
         right_val = 0;
         phase = PH_IDLE;
         eval_count = '0;
         asked_point = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] data);
         case (idx)
            CSR_TOLERANCE: tolerance = data;
            CSR_MAX_EVAL:  max_evaluations = data[COUNT_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function longint unsigned gap_of(longint x, longint y);
         if (x >= y) return x - y;
         return y - x;
      endfunction

      function longint unsigned magnitude(longint x);
         if (x < 0) return -x;
         return x;
      endfunction

      // Move from x toward y by G2 of the distance, rounded on the magnitude.
      function longint golden_point(longint x, longint y);
         longint unsigned mag, q;
         mag = gap_of(x, y);
         q = (mag >> Q_SHIFT) * G2_Q16 + (((mag & 64'hFFFF) * G2_Q16 + ROUND_HALF) >> Q_SHIFT);
         if (y >= x) return x + longint'(q);
         return x - longint'(q);
      endfunction

      function void post(kind_type kind, longint p, longint v);
         answer_type a;
         a.kind = kind;
         a.point = p[VW-1:0];
         a.min_value = v[VW-1:0];
         due_answers.push_back(a);
         if (kind == KIND_EVAL) asked_point = p;
      endfunction

      // Both inner values known: finish, or shrink the bracket and ask for one point.
      function void settle();
         longint unsigned s, bound;
         s = magnitude(left_pt) + magnitude(right_pt);
         bound = (s >> Q_SHIFT) * tolerance + (((s & 64'hFFFF) * tolerance) >> Q_SHIFT);
         if (gap_of(high_end, low_end) <= bound || eval_count >= max_evaluations) begin
            phase = PH_IDLE;
            answers++;
            if (left_val < right_val) post(KIND_FINAL, left_pt, left_val);
            else post(KIND_FINAL, right_pt, right_val);
         end else if (right_val > left_val) begin
            high_end = right_pt;
            right_pt = left_pt;
            right_val = left_val;
            left_pt = golden_point(left_pt, low_end);
            phase = PH_LEFT;
            post(KIND_EVAL, left_pt, 0);
         end else begin
            low_end = left_pt;
            left_pt = right_pt;
            left_val = right_val;
            right_pt = golden_point(right_pt, high_end);
            phase = PH_RIGHT;
            post(KIND_EVAL, right_pt, 0);
         end
      endfunction

      function void take_request(mode_type m, logic [VW-1:0] a, logic [VW-1:0] b,
                                 logic [VW-1:0] c, logic [VW-1:0] f);
         longint pa, pb, pc, fv;
         pa = $signed(a);
         pb = $signed(b);
         pc = $signed(c);
         fv = $signed(f);
         if (m == MODE_START) begin
            starts++;
            low_end = pa;
            high_end = pc;
            if (gap_of(pc, pb) > gap_of(pb, pa)) begin
               left_pt = pb;
               right_pt = golden_point(pb, pc);
            end else begin
               right_pt = pb;
               left_pt = golden_point(pb, pa);
            end
            left_val = 0;
            right_val = 0;
            eval_count = '0;
            phase = PH_FIRST_LEFT;
            post(KIND_EVAL, left_pt, 0);
            return;
         end
         case (phase)
            PH_FIRST_LEFT: begin
               values++;
               left_val = fv;
               eval_count = 1;
               phase = PH_FIRST_RIGHT;
               post(KIND_EVAL, right_pt, 0);
            end
            PH_FIRST_RIGHT: begin
               values++;
               right_val = fv;
               eval_count = 2;
               settle();
            end
            PH_LEFT: begin
               values++;
               left_val = fv;
               eval_count++;
               settle();
            end
            PH_RIGHT: begin
               values++;
               right_val = fv;
               eval_count++;
               settle();
            end
            default: begin
               strays++;
               post(KIND_IDLE, 0, 0);
            end
         endcase
      endfunction

      function void check_result(logic [1:0] kind, logic [VW-1:0] pt, logic [VW-1:0] mv);
         answer_type want;
         if (due_answers.size() == 0) begin
            $error("result word with nothing due: kind %0d point %h", kind, pt);
            failures++;
            return;
         end
         want = due_answers.pop_front();
         checked++;
         if (kind !== want.kind) begin
            $error("result_kind: expected %0d, actual %0d", want.kind, kind);
            failures++;
         end
         if (pt !== want.point) begin
            $error("point: expected %h, actual %h", want.point, pt);
            failures++;
         end
         if (mv !== want.min_value) begin
            $error("min_value: expected %h, actual %h", want.min_value, mv);
            failures++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_mode = MODE_START;
   logic signed [VW-1:0]          req_point_a = '0;
   logic signed [VW-1:0]          req_point_b = '0;
   logic signed [VW-1:0]          req_point_c = '0;
   logic signed [VW-1:0]          req_func_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [1:0]                    rsp_result_kind;
   logic signed [VW-1:0]          rsp_point;
   logic signed [VW-1:0]          rsp_min_value;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index = CSR_TOLERANCE;
   logic [CSR_DATA_WIDTH-1:0]     csr_data = '0;

   minimizer_board_type board = new();
   bit             steady = 1'b0;      // high: neither side idles
   int             useful_words = 0;   // words that do more than get flagged as stray
   int             reg_writes = 0;
   int             cycle_count = 0;

   // Outside evaluator: a V-shaped bowl; a large shift flattens it into steps so ties occur.
   longint         bowl_center = 0;
   longint         bowl_floor = 0;
   int             bowl_shift = 0;

   golden_section_minimizer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_point_a     (req_point_a),
      .req_point_b     (req_point_b),
      .req_point_c     (req_point_c),
      .req_func_value  (req_func_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_point       (rsp_point),
      .rsp_min_value   (rsp_min_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Receiver: stall at random unless in the steady stretch.
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 35);
   end

   // Check every result word the block hands over.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_result_kind, rsp_point, rsp_min_value);
   end

   // Bail out if the block stops talking.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               board.due_answers.size());
      $display("status: fail");
      $finish;
   end

   function automatic logic [VW-1:0] landscape(longint x);
      longint d;
      d = (x >= bowl_center) ? x - bowl_center : bowl_center - x;
      d = (d >>> bowl_shift) + bowl_floor;
      if (d > TOP_VALUE) d = TOP_VALUE;
      return d[VW-1:0];
   endfunction

   // Offer one word, idling first at random; leave valid high after the handshake.
   task automatic send_word(input mode_type m, input logic [VW-1:0] a, input logic [VW-1:0] b,
                            input logic [VW-1:0] c, input logic [VW-1:0] f);
      bit stray;
      while (!steady && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= m;
      req_point_a    <= a;
      req_point_b    <= b;
      req_point_c    <= c;
      req_func_value <= f;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      stray = (m == MODE_VALUE) && (board.phase == PH_IDLE);
      board.take_request(m, a, b, c, f);
      if (!stray) useful_words++;
   endtask

   // Drop valid and hold until every due result word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.due_answers.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_register(idx, data);
      reg_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_search(input logic [CSR_DATA_WIDTH-1:0] tol,
                             input logic [CSR_DATA_WIDTH-1:0] budget);
      drain();
      write_register(CSR_TOLERANCE, tol);
      write_register(CSR_MAX_EVAL, budget);
   endtask

   // Start a search and answer every point it asks for; stop early after quit_after values
   // or once the word target is met, so a stalled search cannot run far past it.
   task automatic run_search(input logic [VW-1:0] a, input logic [VW-1:0] b,
                             input logic [VW-1:0] c, input int quit_after);
      int            steps;
      logic [VW-1:0] f;
      steps = 0;
      send_word(MODE_START, a, b, c, $urandom());
      while (board.phase != PH_IDLE && steps != quit_after && useful_words < WORD_TARGET) begin
         f = ($urandom_range(99) < 4) ? $urandom() : landscape(board.asked_point);
         if ($urandom_range(99) < 3) drain();
         send_word(MODE_VALUE, $urandom(), $urandom(), $urandom(), f);
         steps++;
      end
   endtask

   initial begin
      longint lo, hi, mid, wid;
      int     round_no;
      int     roll;
      logic [CSR_DATA_WIDTH-1:0] tol, budget;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: stray values at the value extremes while nothing runs.
      send_word(MODE_VALUE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_word(MODE_VALUE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000);

      // Widest bracket; extreme function values; pause for the block to drain mid-search.
      send_word(MODE_START, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0);
      send_word(MODE_VALUE, '0, '0, '0, 32'h8000_0000);
      send_word(MODE_VALUE, '0, '0, '0, 32'h7FFF_FFFF);
      drain();
      send_word(MODE_VALUE, '1, '1, '1, 32'h0);

      // Restart while busy with a reversed bracket, then tie the values to step right.
      send_word(MODE_START, 32'h7FFF_FFFF, 32'h7FFF_0000, 32'h8000_0000, '1);
      send_word(MODE_VALUE, '0, '0, '0, 32'd5);
      send_word(MODE_VALUE, '0, '0, '0, 32'd5);
      send_word(MODE_VALUE, '0, '0, '0, 32'd5);

      // Budget below two still fetches both values; a tie reports the right point.
      set_search(16'hFFFF, 16'd1);
      send_word(MODE_START, -32'sd65536, 32'sd0, 32'sd65536, '0);
      send_word(MODE_VALUE, '0, '0, '0, 32'd7);
      send_word(MODE_VALUE, '0, '0, '0, 32'd7);
      send_word(MODE_START, '0, '0, '0, '0);
      send_word(MODE_VALUE, '0, '0, '0, -32'sd3);
      send_word(MODE_VALUE, '0, '0, '0, 32'd9);

      // Zero tolerance: step left once, stop on the budget, then a stray after the answer.
      set_search(16'd0, 16'd3);
      send_word(MODE_START, -32'sd6553600, -32'sd655360, 32'sd3276800, '0);
      send_word(MODE_VALUE, '0, '0, '0, 32'd1);
      send_word(MODE_VALUE, '0, '0, '0, 32'd2);
      send_word(MODE_VALUE, '0, '0, '0, 32'd0);
      send_word(MODE_VALUE, '0, '0, '0, 32'd4);

      // Random searches; rotate the budget through its extremes every few searches.
      round_no = 0;
      useful_words = 0;
      while (useful_words < WORD_TARGET) begin
         if (round_no % 4 == 0) begin
            case ($urandom_range(3))
               0:       tol = 16'd0;
               1:       tol = 16'hFFFF;
               2:       tol = TOL_RESET;
               default: tol = $urandom_range(2000);
            endcase
            case ((round_no / 4) % 4)
               0:       budget = 16'd2;
               1:       budget = 16'd1023;
               2:       budget = MAX_EVAL_RESET;
               default: budget = $urandom_range(100, 2);
            endcase
            if (tol == 16'd0 && budget > 16'd200) budget = 16'd200;
            set_search(tol, budget);
         end
         round_no++;
         steady = (useful_words >= 150 && useful_words < 260);

         roll = $urandom_range(99);
         if (roll < 8) begin
            // noise: a value word that may land on an idle block
            send_word(MODE_VALUE, $urandom(), $urandom(), $urandom(), $urandom());
         end else if (roll < 18) begin
            // noise: a random bracket, usually cut short by the next start
            run_search($urandom(), $urandom(), $urandom(), $urandom_range(6));
         end else begin
            lo  = longint'($signed($urandom())) >>> $urandom_range(31);
            wid = longint'($urandom()) >> $urandom_range(31);
            hi  = lo + wid;
            if (hi > TOP_VALUE) hi = TOP_VALUE;
            mid = lo + (hi - lo) * $urandom_range(1000) / 1000;
            bowl_center = lo + (hi - lo) * $urandom_range(1000) / 1000;
            bowl_floor  = longint'($signed($urandom())) >>> 1;
            bowl_shift  = ($urandom_range(9) == 0) ? $urandom_range(30, 18) : $urandom_range(12);
            if ($urandom_range(1))
               run_search(lo[VW-1:0], mid[VW-1:0], hi[VW-1:0],
                          ($urandom_range(19) == 0) ? $urandom_range(8) : -1);
            else
               run_search(hi[VW-1:0], mid[VW-1:0], lo[VW-1:0], -1);
         end
      end
      steady = 1'b0;

      // Let the last result words come home, then give the verdict.
      drain();
      repeat (4) @(posedge clock);
      $display("searches started %0d, values fed %0d, answers %0d, stray values %0d",
               board.starts, board.values, board.answers, board.strays);
      $display("register writes %0d, result words checked %0d, failures %0d",
               reg_writes, board.checked, board.failures);
      if (board.failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* sim.f */
src/gsm_pkg.sv
src/gsm_step.sv
src/gsm_stop.sv
src/gsm_core.sv
src/golden_section_minimizer.sv
dv/tb_top.sv
